@@ hw/rtl/hashed_key_table_find_or_insert_core_defines.svh @@
// Assertion helpers for the key table core.
// Both expect clk_i and rst_ni to be visible where they are used.
`ifndef HASHED_KEY_TABLE_FIND_OR_INSERT_CORE_DEFINES_SVH
`define HASHED_KEY_TABLE_FIND_OR_INSERT_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define HKT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define HKT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/hkt_pkg.sv @@
// ----------------------------------------------------------------------------
// Key table shared definitions
// Sizes, codes, state types and the hash fold used by the key table core.
// ----------------------------------------------------------------------------
`default_nettype none

package hkt_pkg;

  localparam int unsigned Entries    = 1024;
  localparam int unsigned BucketBits = 14;
  localparam int unsigned NBuckets   = 1 << BucketBits;
  localparam int unsigned IdW        = $clog2(Entries + 1);
  localparam int unsigned AddrW      = $clog2(Entries);
  localparam int unsigned ClrLen     = (NBuckets > Entries) ? NBuckets : Entries;
  localparam int unsigned ClrW       = $clog2(ClrLen);
  localparam int unsigned KeyW       = 256;
  localparam int unsigned QueueDepth = 2;

  localparam logic [31:0] HashMult  = 32'd591798841;
  localparam logic [63:0] HashBasis = 64'd14695981039346656037;

  localparam logic [1:0] FuncLookup = 2'd0;
  localparam logic [1:0] FuncCreate = 2'd1;
  localparam logic [1:0] FuncDelete = 2'd2;

  typedef enum logic [2:0] {
    ST_FOUND     = 3'd0,
    ST_CREATED   = 3'd1,
    ST_NOTFOUND  = 3'd2,
    ST_DELETED   = 3'd3,
    ST_DOUBLE    = 3'd4,
    ST_FULL      = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_ADD,
    F_PUSH
  } front_state_e;

  typedef enum logic [3:0] {
    B_CLEAR,
    B_IDLE,
    B_START,
    B_DCHK,
    B_HEAD,
    B_WALK,
    B_CMP,
    B_ALLOC,
    B_AREAD,
    B_WRKEY,
    B_LINK,
    B_DFREE,
    B_DONE
  } back_state_e;

  typedef struct packed {
    logic [1:0]            func;
    logic [3:0][63:0]      key;
    logic [IdW-1:0]        target;
    logic [BucketBits-1:0] bucket;
  } hkt_item_t;

  // Folds the 64-bit hash to 32 bits, mixes the halves and keeps the bucket bits.
  function automatic logic [BucketBits-1:0] bucket_fold(input logic [63:0] h);
    logic [31:0] x;
    x = h[31:0] ^ h[63:32];
    x = x ^ (x >> 16);
    return x[BucketBits-1:0];
  endfunction

  // Entry ids start at one; the per-entry stores are addressed from zero.
  function automatic logic [AddrW-1:0] id_addr(input logic [IdW-1:0] id);
    logic [IdW-1:0] t;
    t = id - IdW'(1);
    return t[AddrW-1:0];
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/hkt_ram.sv @@
// ----------------------------------------------------------------------------
// Key table generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hkt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hw/rtl/hkt_front.sv @@
// ----------------------------------------------------------------------------
// Key table front end
// Accepts an item; hashes lookup and create keys to a bucket in shared rounds.
// ----------------------------------------------------------------------------
`default_nettype none

module hkt_front import hkt_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  func_i,
  input  wire logic [63:0] key_word0_i,
  input  wire logic [63:0] key_word1_i,
  input  wire logic [63:0] key_word2_i,
  input  wire logic [63:0] key_word3_i,
  input  wire logic [IdW-1:0] target_id_i,
  input  wire logic        full_i,
  output logic             push_o,
  output hkt_item_t        item_o
);

  front_state_e state_q, state_d;
  logic [1:0]   step_q, step_d;
  hkt_item_t    item_q;
  logic [63:0]  h_q, pl_q;
  logic [31:0]  ph_q;
  logic [63:0]  word, x;
  logic         accept;

  assign accept = in_valid_i && (state_q == F_IDLE);

  // Words are folded in the order 0, 2, 1, 3.
  always_comb begin
    case (step_q)
      2'd0:    word = item_q.key[0];
      2'd1:    word = item_q.key[2];
      2'd2:    word = item_q.key[1];
      default: word = item_q.key[3];
    endcase
    x = h_q ^ word;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          state_d = (func_i == FuncDelete) ? F_PUSH : F_MUL;
        end
      end
      F_MUL:  state_d = F_ADD;
      F_ADD:  state_d = (step_q == 2'd3) ? F_PUSH : F_MUL;
      F_PUSH: begin
        if (!full_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != F_IDLE);
    push_o     = (state_q == F_PUSH);
    step_d     = step_q;
    if (accept) begin
      step_d = 2'd0;
    end else if (state_q == F_ADD) begin
      step_d = step_q + 2'd1;
    end
    item_o        = item_q;
    item_o.bucket = bucket_fold(h_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      step_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // The low 64 bits of a 64 by 32 product, from two 32 by 32 halves.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.func   <= func_i;
      item_q.key[0] <= key_word0_i;
      item_q.key[1] <= key_word1_i;
      item_q.key[2] <= key_word2_i;
      item_q.key[3] <= key_word3_i;
      item_q.target <= target_id_i;
      item_q.bucket <= '0;
      h_q           <= HashBasis;
    end else if (state_q == F_ADD) begin
      h_q <= pl_q + {ph_q, 32'd0};
    end
    if (state_q == F_MUL) begin
      pl_q <= x[31:0] * HashMult;
      ph_q <= x[63:32] * HashMult;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/hkt_queue.sv @@
// ----------------------------------------------------------------------------
// Key table item queue
// A short first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module hkt_queue import hkt_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire hkt_item_t item_i,
  output logic           full_o,
  input  wire logic      pop_i,
  output logic           empty_o,
  output hkt_item_t      item_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);

  hkt_item_t         mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]     cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == (PtrW + 1)'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = do_push ? wr_q + PtrW'(1) : wr_q;
    rd_d  = do_pop  ? rd_q + PtrW'(1) : rd_q;
    cnt_d = cnt_q + (PtrW + 1)'(do_push) - (PtrW + 1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/hkt_back.sv @@
// ----------------------------------------------------------------------------
// Key table back end
// Walks bucket chains, allocates and frees ids and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module hkt_back import hkt_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  empty_i,
  input  wire hkt_item_t             item_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [IdW-1:0]             entry_id_o,
  output logic [2:0]                 status_o,
  output logic [BucketBits-1:0]      bucket_o
);

  back_state_e           state_q, state_d;
  logic [ClrW-1:0]       clr_q, clr_d;
  hkt_item_t             item_q, item_d;
  logic [IdW-1:0]        cur_q, cur_d, prev_q, prev_d, nt_q, nt_d;
  logic [BucketBits-1:0] b_q, b_d;
  logic [IdW-1:0]        res_id_q, res_id_d;
  status_e               res_st_q, res_st_d;
  logic [BucketBits-1:0] res_bkt_q, res_bkt_d;
  logic [IdW-1:0]        fc_q, fc_d, issued_q, issued_d;
  logic                  out_valid_q, out_valid_d, out_load;
  logic [IdW-1:0]        out_id_q;
  status_e               out_st_q;
  logic [BucketBits-1:0] out_bkt_q;

  logic                  is_del, is_create, tgt_ok;

  // Bucket heads.
  logic                  hd_we;
  logic [BucketBits-1:0] hd_waddr, hd_raddr;
  logic [IdW-1:0]        hd_wdata, hd_rdata;
  // Chain links.
  logic                  nx_we;
  logic [AddrW-1:0]      nx_waddr, nx_raddr;
  logic [IdW-1:0]        nx_wdata, nx_rdata;
  // Stored keys.
  logic                  ky_we;
  logic [AddrW-1:0]      ky_waddr, ky_raddr;
  logic [KeyW-1:0]       ky_rdata;
  // Live flags.
  logic                  lv_we, lv_wdata, lv_rdata;
  logic [AddrW-1:0]      lv_waddr, lv_raddr;
  // Bucket of each live id.
  logic                  bk_we;
  logic [AddrW-1:0]      bk_waddr, bk_raddr;
  logic [BucketBits-1:0] bk_rdata;
  // Free stack.
  logic                  fs_we;
  logic [AddrW-1:0]      fs_waddr, fs_raddr;
  logic [IdW-1:0]        fs_rdata;

  assign is_del    = (item_q.func == FuncDelete);
  assign is_create = (item_q.func == FuncCreate);
  assign tgt_ok    = (item_q.target != '0) && (item_q.target <= IdW'(Entries));
  assign out_load  = (state_q == B_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_CLEAR: begin
        if (clr_q == ClrW'(ClrLen - 1)) begin
          state_d = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!empty_i) begin
          state_d = B_START;
        end
      end
      B_START: begin
        if (!is_del) begin
          state_d = B_HEAD;
        end else if (tgt_ok) begin
          state_d = B_DCHK;
        end else begin
          state_d = B_DONE;
        end
      end
      B_DCHK:  state_d = lv_rdata ? B_HEAD : B_DONE;
      B_HEAD:  state_d = B_WALK;
      B_WALK: begin
        if (is_del) begin
          state_d = ((cur_q == '0) || (cur_q == item_q.target)) ? B_DFREE : B_CMP;
        end else if (cur_q != '0) begin
          state_d = B_CMP;
        end else begin
          state_d = is_create ? B_ALLOC : B_DONE;
        end
      end
      B_CMP: begin
        state_d = (!is_del && (ky_rdata == item_q.key)) ? B_DONE : B_WALK;
      end
      B_ALLOC: begin
        if (fc_q != '0) begin
          state_d = B_AREAD;
        end else if (issued_q < IdW'(Entries)) begin
          state_d = B_WRKEY;
        end else begin
          state_d = B_DONE;
        end
      end
      B_AREAD: state_d = B_WRKEY;
      B_WRKEY: state_d = B_LINK;
      B_LINK:  state_d = B_DONE;
      B_DFREE: state_d = B_DONE;
      B_DONE: begin
        if (out_load) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    pop_o     = 1'b0;
    clr_d     = clr_q;
    item_d    = item_q;
    cur_d     = cur_q;
    prev_d    = prev_q;
    nt_d      = nt_q;
    b_d       = b_q;
    res_id_d  = res_id_q;
    res_st_d  = res_st_q;
    res_bkt_d = res_bkt_q;
    fc_d      = fc_q;
    issued_d  = issued_q;
    hd_we = 1'b0; hd_waddr = b_q; hd_wdata = '0; hd_raddr = b_q;
    nx_we = 1'b0; nx_waddr = '0;  nx_wdata = '0; nx_raddr = id_addr(cur_q);
    ky_we = 1'b0; ky_waddr = id_addr(res_id_q);  ky_raddr = id_addr(cur_q);
    lv_we = 1'b0; lv_waddr = '0;  lv_wdata = 1'b0; lv_raddr = id_addr(item_q.target);
    bk_we = 1'b0; bk_waddr = id_addr(res_id_q);  bk_raddr = id_addr(item_q.target);
    fs_we = 1'b0; fs_waddr = fc_q[AddrW-1:0];
    fs_raddr = id_addr(fc_q);
    case (state_q)
      B_CLEAR: begin
        clr_d    = clr_q + ClrW'(1);
        hd_we    = ({1'b0, clr_q} < (ClrW + 1)'(NBuckets));
        hd_waddr = BucketBits'(clr_q);
        lv_we    = (clr_q < ClrW'(Entries));
        lv_waddr = AddrW'(clr_q);
      end
      B_IDLE: begin
        if (!empty_i) begin
          pop_o  = 1'b1;
          item_d = item_i;
        end
      end
      B_START: begin
        res_id_d  = item_q.target;
        res_st_d  = ST_DOUBLE;
        res_bkt_d = '0;
        b_d       = item_q.bucket;
        hd_raddr  = item_q.bucket;
        nx_raddr  = id_addr(item_q.target);
      end
      B_DCHK: begin
        b_d      = bk_rdata;
        nt_d     = nx_rdata;
        hd_raddr = bk_rdata;
      end
      B_HEAD: begin
        cur_d  = hd_rdata;
        prev_d = '0;
      end
      B_WALK: begin
        if (is_del) begin
          if ((cur_q != '0) && (cur_q == item_q.target)) begin
            // Unlink: the predecessor, or the head, skips over the target.
            if (prev_q == '0) begin
              hd_we    = 1'b1;
              hd_wdata = nt_q;
            end else begin
              nx_we    = 1'b1;
              nx_waddr = id_addr(prev_q);
              nx_wdata = nt_q;
            end
          end
        end else if (cur_q == '0) begin
          res_id_d  = '0;
          res_st_d  = ST_NOTFOUND;
          res_bkt_d = b_q;
        end
      end
      B_CMP: begin
        if (!is_del && (ky_rdata == item_q.key)) begin
          res_id_d  = cur_q;
          res_st_d  = ST_FOUND;
          res_bkt_d = b_q;
        end else begin
          prev_d = cur_q;
          cur_d  = nx_rdata;
        end
      end
      B_ALLOC: begin
        res_bkt_d = b_q;
        if (fc_q != '0) begin
          fc_d = fc_q - IdW'(1);
        end else if (issued_q < IdW'(Entries)) begin
          issued_d = issued_q + IdW'(1);
          res_id_d = issued_q + IdW'(1);
        end else begin
          res_id_d = '0;
          res_st_d = ST_FULL;
        end
      end
      B_AREAD: begin
        res_id_d = fs_rdata;
      end
      B_WRKEY: begin
        ky_we    = 1'b1;
        bk_we    = 1'b1;
        lv_we    = 1'b1;
        lv_waddr = id_addr(res_id_q);
        lv_wdata = 1'b1;
        nx_we    = 1'b1;
        nx_waddr = id_addr(res_id_q);
        nx_wdata = '0;
      end
      B_LINK: begin
        res_st_d = ST_CREATED;
        if (prev_q == '0) begin
          hd_we    = 1'b1;
          hd_wdata = res_id_q;
        end else begin
          nx_we    = 1'b1;
          nx_waddr = id_addr(prev_q);
          nx_wdata = res_id_q;
        end
      end
      B_DFREE: begin
        lv_we     = 1'b1;
        lv_waddr  = id_addr(item_q.target);
        res_st_d  = ST_DELETED;
        res_bkt_d = b_q;
        if (fc_q < IdW'(Entries)) begin
          fs_we = 1'b1;
          fc_d  = fc_q + IdW'(1);
        end
      end
      B_DONE: ;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      clr_q       <= '0;
      fc_q        <= '0;
      issued_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      fc_q        <= fc_d;
      issued_q    <= issued_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    cur_q     <= cur_d;
    prev_q    <= prev_d;
    nt_q      <= nt_d;
    b_q       <= b_d;
    res_id_q  <= res_id_d;
    res_st_q  <= res_st_d;
    res_bkt_q <= res_bkt_d;
    if (out_load) begin
      out_id_q  <= res_id_q;
      out_st_q  <= res_st_q;
      out_bkt_q <= res_bkt_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign entry_id_o  = out_id_q;
  assign status_o    = out_st_q;
  assign bucket_o    = out_bkt_q;

  hkt_ram #(.Width(IdW), .Depth(NBuckets)) u_heads (
    .clk_i, .we_i(hd_we), .waddr_i(hd_waddr), .wdata_i(hd_wdata),
    .raddr_i(hd_raddr), .rdata_o(hd_rdata)
  );

  hkt_ram #(.Width(IdW), .Depth(Entries)) u_next (
    .clk_i, .we_i(nx_we), .waddr_i(nx_waddr), .wdata_i(nx_wdata),
    .raddr_i(nx_raddr), .rdata_o(nx_rdata)
  );

  hkt_ram #(.Width(KeyW), .Depth(Entries)) u_keys (
    .clk_i, .we_i(ky_we), .waddr_i(ky_waddr), .wdata_i(item_q.key),
    .raddr_i(ky_raddr), .rdata_o(ky_rdata)
  );

  hkt_ram #(.Width(1), .Depth(Entries)) u_live (
    .clk_i, .we_i(lv_we), .waddr_i(lv_waddr), .wdata_i(lv_wdata),
    .raddr_i(lv_raddr), .rdata_o(lv_rdata)
  );

  hkt_ram #(.Width(BucketBits), .Depth(Entries)) u_bkt (
    .clk_i, .we_i(bk_we), .waddr_i(bk_waddr), .wdata_i(b_q),
    .raddr_i(bk_raddr), .rdata_o(bk_rdata)
  );

  hkt_ram #(.Width(IdW), .Depth(Entries)) u_free (
    .clk_i, .we_i(fs_we), .waddr_i(fs_waddr), .wdata_i(item_q.target),
    .raddr_i(fs_raddr), .rdata_o(fs_rdata)
  );

endmodule

`default_nettype wire

@@ hw/rtl/hashed_key_table_find_or_insert_core.sv @@
// ----------------------------------------------------------------------------
// Hashed key table, find or insert
// Maps 256-bit keys to entry ids through hashed buckets with chained entries.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake               Payload
//   in       to block   in_valid_i/in_stall_o   func, four key words, target id
//   out      from block out_valid_o/out_stall_i entry id, status, bucket
//
// The front end hashes a lookup or create in four rounds of a multiply step
// and an add step, one round per key word; a delete skips the hash.
// The back end reads the link and key stores once per chain link walked; a
// create adds allocate, key write and link steps, and a free-stack read.
// After reset a clearing pass zeroes the 16384 bucket heads and the live
// flags; items are queued by the front end but not executed meanwhile.
// A stalled result holds the back end; the two-deep queue still fills.
`default_nettype none
`include "hashed_key_table_find_or_insert_core_defines.svh"

module hashed_key_table_find_or_insert_core import hkt_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [1:0]            func_i,
  input  wire logic [63:0]           key_word0_i,
  input  wire logic [63:0]           key_word1_i,
  input  wire logic [63:0]           key_word2_i,
  input  wire logic [63:0]           key_word3_i,
  input  wire logic [IdW-1:0]        target_id_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [IdW-1:0]             entry_id_o,
  output logic [2:0]                 status_o,
  output logic [BucketBits-1:0]      bucket_o
);

  // Items move from the front end into the queue as whole structures.
  hkt_item_t front_item, queue_item;
  logic      push, full, pop, empty;

  hkt_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .func_i,
    .key_word0_i, .key_word1_i, .key_word2_i, .key_word3_i, .target_id_i,
    .full_i(full), .push_o(push), .item_o(front_item)
  );

  hkt_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .item_i(front_item), .full_o(full),
    .pop_i(pop), .empty_o(empty), .item_o(queue_item)
  );

  // The back end owns every store and the output register.
  hkt_back u_back (
    .clk_i, .rst_ni, .empty_i(empty), .item_i(queue_item), .pop_o(pop),
    .out_valid_o, .out_stall_i, .entry_id_o, .status_o, .bucket_o
  );

  // A found or created result always names a real entry.
  `HKT_ASSERT_IMP(a_hit_has_id,
    out_valid_o && ((status_o == ST_FOUND) || (status_o == ST_CREATED)),
    entry_id_o != '0, "found or created result without an id")

  // Misses and a full table report no id.
  `HKT_ASSERT_IMP(a_miss_no_id,
    out_valid_o && ((status_o == ST_NOTFOUND) || (status_o == ST_FULL)),
    entry_id_o == '0, "miss or full result carries an id")

  // The front end is busy in the cycle after taking an item.
  `HKT_ASSERT_NXT(a_front_busy, in_valid_i && !in_stall_o, in_stall_o,
    "front end took two items in consecutive cycles")

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// Key table find-or-insert testbench
// Drives lookups, creates and deletes through the input channel with random
// bursts and gaps, predicts each result from a model of the table kept here,
// and checks every result field against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import hkt_pkg::*;

  localparam int unsigned NumRandom = 500;

  // The unused function code, which behaves as a lookup.
  localparam logic [1:0] FuncSpare = 2'd3;

  typedef struct {
    logic [1:0]     func;
    logic [63:0]    w [4];
    logic [IdW-1:0] target;
  } req_t;

  typedef struct {
    logic [IdW-1:0]        id;
    logic [2:0]            status;
    logic [BucketBits-1:0] bucket;
  } resp_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [1:0]            func_i = '0;
  logic [63:0]           key_word0_i = '0;
  logic [63:0]           key_word1_i = '0;
  logic [63:0]           key_word2_i = '0;
  logic [63:0]           key_word3_i = '0;
  logic [IdW-1:0]        target_id_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [IdW-1:0]        entry_id_o;
  logic [2:0]            status_o;
  logic [BucketBits-1:0] bucket_o;

  hashed_key_table_find_or_insert_core u_top (.*);

  always #5 clk_i = ~clk_i;

  // Shadow copy of the table state.
  logic [IdW-1:0] heads [NBuckets];
  logic [IdW-1:0] links [Entries+1];
  logic [63:0]    keys  [Entries+1][4];
  bit             live  [Entries+1];
  logic [IdW-1:0] freed [$];
  logic [IdW-1:0] issued;

  req_t  pending_items [$];
  resp_t expected_results [$];
  int    mismatches;
  bit    all_sent;

  // Keys created so far, so that random lookups and creates can hit them.
  logic [63:0] known_keys [$][4];

  function automatic logic [BucketBits-1:0] hash_bucket(input logic [63:0] w [4]);
    logic [63:0] h;
    logic [31:0] x;
    h = 64'd14695981039346656037;
    h = (h ^ w[0]) * 64'd591798841;
    h = (h ^ w[2]) * 64'd591798841;
    h = (h ^ w[1]) * 64'd591798841;
    h = (h ^ w[3]) * 64'd591798841;
    x = h[31:0] ^ h[63:32];
    x = x ^ (x >> 16);
    return x[BucketBits-1:0];
  endfunction

  function automatic bit same_key(input logic [IdW-1:0] id, input logic [63:0] w [4]);
    return keys[id][0] == w[0] && keys[id][1] == w[1] &&
           keys[id][2] == w[2] && keys[id][3] == w[3];
  endfunction

  // Works out the result of one item and updates the shadow table.
  function automatic resp_t table_step(input req_t r);
    resp_t          o;
    logic [IdW-1:0] cur, prev;
    int unsigned    n;
    o.id = '0;
    o.bucket = '0;
    if (r.func == FuncDelete) begin
      o.id = r.target;
      if (r.target == 0 || r.target > Entries || !live[r.target]) begin
        o.status = ST_DOUBLE;
      end else begin
        o.bucket = hash_bucket(keys[r.target]);
        prev = '0;
        cur = heads[o.bucket];
        for (n = 0; n < Entries && cur != 0; n++) begin
          if (cur == r.target) begin
            if (prev == 0) heads[o.bucket] = links[cur];
            else links[prev] = links[cur];
            break;
          end
          prev = cur;
          cur = links[cur];
        end
        live[r.target] = 1'b0;
        freed.push_back(r.target);
        o.status = ST_DELETED;
      end
    end else begin
      o.bucket = hash_bucket(r.w);
      cur = heads[o.bucket];
      for (n = 0; n < Entries && cur != 0; n++) begin
        if (same_key(cur, r.w)) break;
        cur = links[cur];
      end
      if (n == Entries) cur = '0;
      if (cur != 0) begin
        o.id = cur;
        o.status = ST_FOUND;
      end else if (r.func != FuncCreate) begin
        o.status = ST_NOTFOUND;
      end else begin
        if (freed.size() > 0) cur = freed.pop_back();
        else if (issued < Entries) begin
          issued++;
          cur = issued;
        end
        if (cur == 0) begin
          o.status = ST_FULL;
        end else begin
          for (n = 0; n < 4; n++) keys[cur][n] = r.w[n];
          live[cur] = 1'b1;
          links[cur] = '0;
          if (heads[o.bucket] == 0) heads[o.bucket] = cur;
          else begin
            prev = heads[o.bucket];
            while (links[prev] != 0) prev = links[prev];
            links[prev] = cur;
          end
          o.id = cur;
          o.status = ST_CREATED;
          known_keys.push_back(r.w);
        end
      end
    end
    return o;
  endfunction

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // Queues an item and its prediction together, in acceptance order.
  task automatic add_item(input logic [1:0] f, input logic [63:0] w [4],
                          input logic [IdW-1:0] t);
    req_t r;
    r.func = f;
    r.w = w;
    r.target = t;
    pending_items.push_back(r);
    expected_results.push_back(table_step(r));
  endtask

  initial begin
    logic [63:0] w [4];
    logic [1:0]  f;
    logic [IdW-1:0] t;
    int k;
    for (k = 0; k < NBuckets; k++) heads[k] = '0;
    for (k = 0; k <= Entries; k++) begin
      links[k] = '0;
      live[k] = 1'b0;
    end
    issued = '0;
    mismatches = 0;
    all_sent = 1'b0;

    // Directed part: extreme keys, every function, unused code, bad deletes.
    w = '{64'd0, 64'd0, 64'd0, 64'd0};
    add_item(FuncLookup, w, '0);
    add_item(FuncCreate, w, '0);
    add_item(FuncLookup, w, '1);
    add_item(FuncSpare, w, '0);
    w = '{'1, '1, '1, '1};
    add_item(FuncCreate, w, '0);
    add_item(FuncCreate, w, '0);
    add_item(FuncDelete, w, 11'd0);
    add_item(FuncDelete, w, 11'd1025);
    add_item(FuncDelete, w, 11'd2047);
    add_item(FuncDelete, w, 11'd1024);
    add_item(FuncDelete, w, 11'd1);
    add_item(FuncDelete, w, 11'd1);
    add_item(FuncLookup, '{64'd0, 64'd0, 64'd0, 64'd0}, '0);
    add_item(FuncCreate, '{64'd1, 64'd0, 64'd0, 64'd0}, '0);
    add_item(FuncCreate, '{64'd0, 64'd0, 64'd0, 64'h8000_0000_0000_0000}, '0);
    add_item(FuncDelete, w, 11'd2);
    add_item(FuncCreate, '{64'h5555_5555_5555_5555, '0, '1, 64'hAAAA_AAAA_AAAA_AAAA}, '0);

    // Random part: mostly creates and lookups of known keys, some deletes.
    for (k = 0; k < NumRandom; k++) begin
      t = IdW'($urandom_range(1, issued + 2));
      if ($urandom_range(0, 9) == 0) t = IdW'($urandom());
      if (known_keys.size() > 0 && $urandom_range(0, 2) != 0)
        w = known_keys[$urandom_range(0, known_keys.size() - 1)];
      else
        w = '{rand_word(), rand_word(), rand_word(), rand_word()};
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: f = FuncCreate;
        5, 6:          f = FuncLookup;
        7:             f = FuncSpare;
        default:       f = FuncDelete;
      endcase
      add_item(f, w, t);
    end

    // Fill the table to the top to reach the full case, then drain a little.
    while (issued < Entries || freed.size() > 0) begin
      w = '{{$urandom(), $urandom()}, {$urandom(), $urandom()}, 64'd7, 64'd9};
      add_item(FuncCreate, w, '0);
    end
    for (k = 0; k < 4; k++) begin
      w = '{{$urandom(), $urandom()}, 64'd1, 64'd2, 64'd3};
      add_item(FuncCreate, w, '0);
    end
    for (k = 0; k < 20; k++) begin
      w = '{{$urandom(), $urandom()}, 64'd1, 64'd2, 64'd3};
      add_item(FuncDelete, w, IdW'($urandom_range(1, Entries)));
      add_item(FuncCreate, w, '0);
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // Records at each rising edge whether the item on the port was taken.
  bit in_stall_accepted = 1'b1;
  always @(posedge clk_i) begin
    in_stall_accepted <= !in_valid_i || !in_stall_o;
  end

  // Driver: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_accepted) begin
        // Payload held while stalled.
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (pending_items.size() > 0) begin
        func_i <= pending_items[0].func;
        key_word0_i <= pending_items[0].w[0];
        key_word1_i <= pending_items[0].w[1];
        key_word2_i <= pending_items[0].w[2];
        key_word3_i <= pending_items[0].w[3];
        target_id_i <= pending_items[0].target;
        void'(pending_items.pop_front());
        in_valid_i <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
        all_sent <= 1'b1;
      end
    end
  end

  // Receiver stall pattern: long quiet stretches and bursts of stalls.
  int stall_phase = 0;
  always @(negedge clk_i) begin
    stall_phase <= (stall_phase + 1) % 400;
    if (stall_phase < 150) out_stall_i <= 1'b0;
    else if (stall_phase < 250) out_stall_i <= ($urandom_range(0, 2) == 0);
    else out_stall_i <= ($urandom_range(0, 9) < 6);
  end

  // Monitor: compares every accepted result with the oldest prediction.
  always @(posedge clk_i) begin
    resp_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10)
          $display("unexpected result id=%0d status=%0d bucket=%0d",
                   entry_id_o, status_o, bucket_o);
      end else begin
        e = expected_results.pop_front();
        if (entry_id_o !== e.id || status_o !== e.status || bucket_o !== e.bucket) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("mismatch: expected id=%0d status=%0d bucket=%0d, got %0d %0d %0d",
                     e.id, e.status, e.bucket, entry_id_o, status_o, bucket_o);
        end
      end
    end
  end

  initial begin
    wait (rst_ni && all_sent && expected_results.size() == 0);
    repeat (200) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Allows for the clearing pass, long chain walks and heavy stalling.
  initial begin
    #20000000;
    $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire
